// File: hdl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// shared types and constants of the sobel edge magnitude core
// ----------------------------------------------------------------------------
package sem_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int DIM_W = 11;                  // register and dimension width
   localparam int COL_W = $clog2(MAX_WIDTH);   // column index
   localparam int ROW_W = $clog2(MAX_HEIGHT);  // emitted row index

   localparam logic [DIM_W-1:0] DIM_MIN       = DIM_W'(3);
   localparam logic [DIM_W-1:0] WIDTH_MAX     = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] HEIGHT_MAX    = DIM_W'(MAX_HEIGHT);
   localparam logic [DIM_W-1:0] WIDTH_RESET   = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_RESET  = DIM_W'(480);

   // register indexes
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   // opcodes
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // divide by three as multiply by reciprocal, exact for sums below 2048
   localparam logic [9:0] THIRD_MUL   = 10'd683;
   localparam int         THIRD_SHIFT = 11;

   localparam logic [7:0]  MAG_MAX   = 8'd255;
   localparam logic [16:0] SQ_LIMIT  = 17'd65025;

   localparam int MQ_DEPTH  = 4;
   localparam int MQ_PTR_W  = $clog2(MQ_DEPTH);
   localparam int OQ_DEPTH  = 32;
   localparam int OQ_PTR_W  = $clog2(OQ_DEPTH);

   // classified beat passed from front to back
   typedef struct packed {
      logic [7:0]       gray;
      logic [7:0]       alpha;
      logic [COL_W-1:0] col;
      logic             emit;
      logic             interior;
      logic             last;
   } sem_item_type;

   // side data travelling alongside the magnitude datapath
   typedef struct packed {
      logic [7:0] alpha;
      logic       interior;
      logic       sat;
      logic       last;
   } sem_meta_type;

   typedef struct packed {
      logic [7:0] magnitude;
      logic [7:0] alpha;
      logic       last;
   } sem_result_type;

endpackage

// File: hdl/sobel_edge_magnitude_core.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_core
// a result reaches the result ports through the beat queue, back pipeline and result queue
// throughput: one beat per cycle while results are taken; each line store does
// one read and one write a cycle; full rises once the beat queue is full
// reset: synchronous, clears pointers, counters and valids; frame 640 x 480
// line stores need no clearing: every entry read for a result is written first
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_core (
   input  logic                      clock,
   input  logic                      reset,
   // input beats
   input  logic                      push,
   output logic                      full,
   input  logic                      req_opcode,
   input  logic [7:0]                req_red,
   input  logic [7:0]                req_green,
   input  logic [7:0]                req_blue,
   input  logic [7:0]                req_alpha_in,
   // result beats
   output logic                      empty,
   input  logic                      pop,
   output logic [7:0]                rsp_magnitude,
   output logic [7:0]                rsp_alpha_out,
   output logic                      rsp_frame_last,
   // register writes
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [sem_pkg::DIM_W-1:0] csr_wdata
);

   // front to queue
   logic                  fq_push;
   sem_pkg::sem_item_type fq_item;
   logic                  mq_full;
   logic                  mq_empty;
   sem_pkg::sem_item_type mq_head;

   // back end
   logic                   issue;
   logic                   res_vld;
   sem_pkg::sem_result_type res;

   // result queue
   sem_pkg::sem_result_type oq_mem_ff [sem_pkg::OQ_DEPTH];
   logic [sem_pkg::OQ_PTR_W-1:0] oq_wr_ff, oq_wr_in;
   logic [sem_pkg::OQ_PTR_W-1:0] oq_rd_ff, oq_rd_in;
   logic [sem_pkg::OQ_PTR_W:0]   oq_cnt_ff, oq_cnt_in;
   // queue entries plus results still in the back pipeline
   logic [sem_pkg::OQ_PTR_W:0]   resv_ff, resv_in;
   logic                         oq_pop;

   // front end: accept, gray conversion, position tracking
   sem_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (push),
      .req_opcode   (req_opcode),
      .req_red      (req_red),
      .req_green    (req_green),
      .req_blue     (req_blue),
      .req_alpha_in (req_alpha_in),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .q_full       (mq_full),
      .q_push       (fq_push),
      .q_item       (fq_item)
   );

   assign full = mq_full;

   sem_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_item (fq_item),
      .pop       (issue),
      .full      (mq_full),
      .empty     (mq_empty),
      .head      (mq_head)
   );

   // a beat giving a result leaves the queue only with room reserved for it
   assign issue = !mq_empty &&
                  (!mq_head.emit || (resv_ff < (sem_pkg::OQ_PTR_W+1)'(sem_pkg::OQ_DEPTH)));

   sem_back u_back (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .issue_item (mq_head),
      .res_vld    (res_vld),
      .res        (res)
   );

   // result queue towards the consumer
   always_comb begin
      empty          = (oq_cnt_ff == '0);
      oq_pop         = pop && !empty;
      rsp_magnitude  = oq_mem_ff[oq_rd_ff].magnitude;
      rsp_alpha_out  = oq_mem_ff[oq_rd_ff].alpha;
      rsp_frame_last = oq_mem_ff[oq_rd_ff].last;
      oq_wr_in  = res_vld ? oq_wr_ff + sem_pkg::OQ_PTR_W'(1) : oq_wr_ff;
      oq_rd_in  = oq_pop ? oq_rd_ff + sem_pkg::OQ_PTR_W'(1) : oq_rd_ff;
      oq_cnt_in = oq_cnt_ff + (sem_pkg::OQ_PTR_W+1)'(res_vld)
                - (sem_pkg::OQ_PTR_W+1)'(oq_pop);
      resv_in   = resv_ff + (sem_pkg::OQ_PTR_W+1)'(issue && mq_head.emit)
                - (sem_pkg::OQ_PTR_W+1)'(oq_pop);
   end

   always_ff @(posedge clock) begin
      if (res_vld) begin
         oq_mem_ff[oq_wr_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= '0;
         oq_rd_ff  <= '0;
         oq_cnt_ff <= '0;
         resv_ff   <= '0;
      end else begin
         oq_wr_ff  <= oq_wr_in;
         oq_rd_ff  <= oq_rd_in;
         oq_cnt_ff <= oq_cnt_in;
         resv_ff   <= resv_in;
      end
   end

endmodule

// File: hdl/sem_front.sv
// ----------------------------------------------------------------------------
// sem_front
// accepts beats, converts to gray, tracks frame position and classifies
// ----------------------------------------------------------------------------
module sem_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   input  logic                       req_opcode,
   input  logic [7:0]                 req_red,
   input  logic [7:0]                 req_green,
   input  logic [7:0]                 req_blue,
   input  logic [7:0]                 req_alpha_in,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [sem_pkg::DIM_W-1:0]  csr_wdata,
   input  logic                       q_full,
   output logic                       q_push,
   output sem_pkg::sem_item_type      q_item
);

   logic [sem_pkg::DIM_W-1:0] width_ff, width_in;
   logic [sem_pkg::DIM_W-1:0] height_ff, height_in;
   logic [sem_pkg::COL_W-1:0] col_ff, col_in;
   logic [sem_pkg::DIM_W-1:0] row_ff, row_in;
   logic [sem_pkg::COL_W-1:0] pc_ff, pc_in;
   logic [sem_pkg::ROW_W-1:0] pr_ff, pr_in;

   logic [sem_pkg::DIM_W-1:0] clamped;
   logic [sem_pkg::DIM_W-1:0] dim_hi;
   logic                      at_start;
   logic                      is_flush;
   logic                      take;
   logic                      emit;
   logic                      interior;
   logic                      last;
   logic                      fire;
   logic [9:0]                sum;
   logic [19:0]               prod;
   logic [sem_pkg::DIM_W-1:0] col_next;
   logic [sem_pkg::DIM_W-1:0] pc_next;

   always_comb begin
      dim_hi = (csr_index == sem_pkg::REG_FRAME_WIDTH) ? sem_pkg::WIDTH_MAX
                                                        : sem_pkg::HEIGHT_MAX;
      if (csr_wdata < sem_pkg::DIM_MIN) begin
         clamped = sem_pkg::DIM_MIN;
      end else if (csr_wdata > dim_hi) begin
         clamped = dim_hi;
      end else begin
         clamped = csr_wdata;
      end
   end

   always_comb begin
      at_start = (col_ff == '0) && (row_ff == '0);
      is_flush = (req_opcode == sem_pkg::OP_FLUSH);
      take     = !is_flush && (row_ff < height_ff);
      emit     = (row_ff > sem_pkg::DIM_W'(1)) ||
                 ((row_ff == sem_pkg::DIM_W'(1)) && (col_ff != '0));
      interior = (pr_ff != '0) &&
                 (sem_pkg::DIM_W'(pr_ff) < height_ff - sem_pkg::DIM_W'(1)) &&
                 (pc_ff != '0) &&
                 (sem_pkg::DIM_W'(pc_ff) < width_ff - sem_pkg::DIM_W'(1));
      last     = emit &&
                 (sem_pkg::DIM_W'(pr_ff) == height_ff - sem_pkg::DIM_W'(1)) &&
                 (sem_pkg::DIM_W'(pc_ff) == width_ff - sem_pkg::DIM_W'(1));
      sum      = 10'(req_red) + 10'(req_green) + 10'(req_blue);
      prod     = 20'(sum) * 20'(sem_pkg::THIRD_MUL);
      fire     = req_push && !q_full && !(is_flush && at_start);
   end

   always_comb begin
      q_push          = fire;
      q_item.gray     = take ? prod[sem_pkg::THIRD_SHIFT +: 8] : 8'd0;
      q_item.alpha    = take ? req_alpha_in : 8'd0;
      q_item.col      = col_ff;
      q_item.emit     = emit;
      q_item.interior = interior;
      q_item.last     = last;
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      pc_in     = pc_ff;
      pr_in     = pr_ff;
      col_next  = sem_pkg::DIM_W'(col_ff) + sem_pkg::DIM_W'(1);
      pc_next   = sem_pkg::DIM_W'(pc_ff) + sem_pkg::DIM_W'(1);
      if (csr_we) begin
         if (csr_index == sem_pkg::REG_FRAME_WIDTH) begin
            width_in = clamped;
         end else begin
            height_in = clamped;
         end
         col_in = '0;
         row_in = '0;
         pc_in  = '0;
         pr_in  = '0;
      end else if (fire) begin
         if (last) begin
            col_in = '0;
            row_in = '0;
            pc_in  = '0;
            pr_in  = '0;
         end else begin
            if (col_next >= width_ff) begin
               col_in = '0;
               row_in = row_ff + sem_pkg::DIM_W'(1);
            end else begin
               col_in = col_next[sem_pkg::COL_W-1:0];
            end
            if (emit) begin
               if (pc_next >= width_ff) begin
                  pc_in = '0;
                  pr_in = pr_ff + sem_pkg::ROW_W'(1);
               end else begin
                  pc_in = pc_next[sem_pkg::COL_W-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sem_pkg::WIDTH_RESET;
         height_ff <= sem_pkg::HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         pc_ff     <= '0;
         pr_ff     <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         pc_ff     <= pc_in;
         pr_ff     <= pr_in;
      end
   end

endmodule

// File: hdl/sem_queue.sv
// ----------------------------------------------------------------------------
// sem_queue
// short queue of classified beats between front and back
// ----------------------------------------------------------------------------
module sem_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sem_pkg::sem_item_type push_item,
   input  logic                  pop,
   output logic                  full,
   output logic                  empty,
   output sem_pkg::sem_item_type head
);

   sem_pkg::sem_item_type mem_ff [sem_pkg::MQ_DEPTH];

   logic [sem_pkg::MQ_PTR_W-1:0] wr_ff, wr_in;
   logic [sem_pkg::MQ_PTR_W-1:0] rd_ff, rd_in;
   logic [sem_pkg::MQ_PTR_W:0]   cnt_ff, cnt_in;

   always_comb begin
      full  = (cnt_ff == (sem_pkg::MQ_PTR_W+1)'(sem_pkg::MQ_DEPTH));
      empty = (cnt_ff == '0);
      head  = mem_ff[rd_ff];
      wr_in = push ? wr_ff + sem_pkg::MQ_PTR_W'(1) : wr_ff;
      rd_in = pop ? rd_ff + sem_pkg::MQ_PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + (sem_pkg::MQ_PTR_W+1)'(push) - (sem_pkg::MQ_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: hdl/sem_sqrt.sv
// ----------------------------------------------------------------------------
// sem_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module sem_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_vld,
   input  logic [15:0]           in_val,
   input  sem_pkg::sem_meta_type in_meta,
   output logic                  out_vld,
   output logic [7:0]            out_root,
   output sem_pkg::sem_meta_type out_meta
);

   logic                  vld_ff  [9];
   logic [15:0]           val_ff  [9];
   logic [7:0]            root_ff [9];
   sem_pkg::sem_meta_type meta_ff [9];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_vld;
      end
      val_ff[0]  <= in_val;
      root_ff[0] <= 8'd0;
      meta_ff[0] <= in_meta;
   end

   for (genvar i = 0; i < 8; i++) begin : g_bit
      logic [7:0]  trial;
      logic [15:0] sq;

      always_comb begin
         trial = root_ff[i] | (8'd1 << (7 - i));
         sq    = 16'(trial) * 16'(trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
         val_ff[i+1]  <= val_ff[i];
         root_ff[i+1] <= (sq <= val_ff[i]) ? trial : root_ff[i];
         meta_ff[i+1] <= meta_ff[i];
      end
   end

   assign out_vld  = vld_ff[8];
   assign out_root = root_ff[8];
   assign out_meta = meta_ff[8];

endmodule

// File: hdl/sem_back.sv
// ----------------------------------------------------------------------------
// sem_back
// line stores, 3x3 window, sobel kernels and magnitude
// ----------------------------------------------------------------------------
module sem_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   issue,
   input  sem_pkg::sem_item_type  issue_item,
   output logic                   res_vld,
   output sem_pkg::sem_result_type res
);

   logic [7:0] upper_mem  [sem_pkg::MAX_WIDTH];
   logic [7:0] middle_mem [sem_pkg::MAX_WIDTH];
   logic [7:0] alpha_mem  [sem_pkg::MAX_WIDTH];

   // stage 1: read data of the line stores
   logic                  s1_vld_ff;
   sem_pkg::sem_item_type s1_item_ff;
   logic [7:0]            u_rd_ff, m_rd_ff, a_rd_ff;

   // window, rows top to bottom, columns left to right
   logic [7:0] win_ff [3][3];
   logic [7:0] alpha_dly_ff;

   // stage 2: window valid
   logic                  s2_vld_ff;
   sem_pkg::sem_meta_type s2_meta_ff;
   // stage 3: gradients
   logic                  s3_vld_ff;
   sem_pkg::sem_meta_type s3_meta_ff;
   logic signed [11:0]    gx_ff, gy_ff;
   // stage 4: squares
   logic                  s4_vld_ff;
   sem_pkg::sem_meta_type s4_meta_ff;
   logic [15:0]           sqx_ff, sqy_ff;
   // stage 5: sum
   logic                  s5_vld_ff;
   sem_pkg::sem_meta_type s5_meta_ff;
   logic [15:0]           sum_ff;

   logic signed [11:0]    gx, gy;
   logic [11:0]           ax, ay;
   logic [16:0]           sum_full;
   sem_pkg::sem_meta_type s4_meta, s5_meta, sq_meta;
   logic                  sq_vld;
   logic [7:0]            sq_root;

   always_ff @(posedge clock) begin
      if (issue) begin
         u_rd_ff <= upper_mem[issue_item.col];
         m_rd_ff <= middle_mem[issue_item.col];
         a_rd_ff <= alpha_mem[issue_item.col];
      end
      s1_item_ff <= issue_item;
      if (s1_vld_ff) begin
         upper_mem[s1_item_ff.col]  <= m_rd_ff;
         middle_mem[s1_item_ff.col] <= s1_item_ff.gray;
         alpha_mem[s1_item_ff.col]  <= s1_item_ff.alpha;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2]        <= u_rd_ff;
         win_ff[1][2]        <= m_rd_ff;
         win_ff[2][2]        <= s1_item_ff.gray;
         alpha_dly_ff        <= a_rd_ff;
         s2_meta_ff.alpha    <= alpha_dly_ff;
      end
      s2_meta_ff.interior <= s1_item_ff.interior;
      s2_meta_ff.last     <= s1_item_ff.last;
      s2_meta_ff.sat      <= 1'b0;
   end

   always_comb begin
      gx = (12'(win_ff[0][2]) + (12'(win_ff[1][2]) << 1) + 12'(win_ff[2][2]))
         - (12'(win_ff[0][0]) + (12'(win_ff[1][0]) << 1) + 12'(win_ff[2][0]));
      gy = (12'(win_ff[0][0]) + (12'(win_ff[0][1]) << 1) + 12'(win_ff[0][2]))
         - (12'(win_ff[2][0]) + (12'(win_ff[2][1]) << 1) + 12'(win_ff[2][2]));
      ax = gx_ff[11] ? 12'(-gx_ff) : 12'(gx_ff);
      ay = gy_ff[11] ? 12'(-gy_ff) : 12'(gy_ff);
      s4_meta     = s3_meta_ff;
      s4_meta.sat = (ax >= 12'(sem_pkg::MAG_MAX)) || (ay >= 12'(sem_pkg::MAG_MAX));
      sum_full    = 17'(sqx_ff) + 17'(sqy_ff);
      s5_meta     = s4_meta_ff;
      s5_meta.sat = s4_meta_ff.sat || (sum_full >= sem_pkg::SQ_LIMIT);
   end

   always_ff @(posedge clock) begin
      gx_ff      <= gx;
      gy_ff      <= gy;
      s3_meta_ff <= s2_meta_ff;
      sqx_ff     <= 16'(ax[7:0]) * 16'(ax[7:0]);
      sqy_ff     <= 16'(ay[7:0]) * 16'(ay[7:0]);
      s4_meta_ff <= s4_meta;
      sum_ff     <= sum_full[15:0];
      s5_meta_ff <= s5_meta;
   end

   // only beats that give a result travel on past the window
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff && s1_item_ff.emit;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
      end
   end

   sem_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (s5_vld_ff),
      .in_val   (sum_ff),
      .in_meta  (s5_meta_ff),
      .out_vld  (sq_vld),
      .out_root (sq_root),
      .out_meta (sq_meta)
   );

   always_comb begin
      res_vld   = sq_vld;
      res.alpha = sq_meta.alpha;
      res.last  = sq_meta.last;
      if (!sq_meta.interior) begin
         res.magnitude = 8'd0;
      end else if (sq_meta.sat) begin
         res.magnitude = sem_pkg::MAG_MAX;
      end else begin
         res.magnitude = sq_root;
      end
   end

endmodule
